// ===== design/hbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_pkg: shared types and constants of the prefix-code decoder
// Field widths fixed by the stream format, the match link carried along the
// cell chain, and the sequencer states.
// ----------------------------------------------------------------------------
package hbd_pkg;

    localparam int SYM_W     = 8;   // decoded symbol
    localparam int IDX_W     = 8;   // table slot index
    localparam int CODE_IN_W = 16;  // code value on a load transaction
    localparam int LEN_IN_W  = 5;   // code length on a load transaction
    localparam int BYTE_W    = 8;   // compressed byte
    localparam int SKIP_W    = 3;   // leading bits dropped at stream start
    localparam int BITS_W    = 3;   // bits still to shift from the held byte
    localparam int CHAIN_LEN = 8;   // cells in one combinational chain segment

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    // Hit flag and symbol handed from cell to cell, lowest index wins
    typedef struct packed {
        logic             hit;
        logic [SYM_W-1:0] symbol;
    } link_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE,
        ST_FLUSH
    } hbd_state_t;

endpackage

// ===== design/hbd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_cell: one code table slot
// Holds valid, length, code and symbol of a slot, compares them with the
// accumulated code and passes either its own hit or its neighbour's along.
// ----------------------------------------------------------------------------
module hbd_cell
    import hbd_pkg::*;
#(
    parameter int MAX_CODE_LEN = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [CODE_IN_W-1:0]                wr_code,
    input  logic [LEN_IN_W-1:0]                 wr_len,
    input  logic [SYM_W-1:0]                    wr_symbol,
    input  logic [MAX_CODE_LEN-1:0]             accum,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0]   accum_len,
    input  link_t                               chain_in,
    output link_t                               chain_out
);

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

    logic                    valid_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [MAX_CODE_LEN-1:0] code_reg;
    logic [SYM_W-1:0]        sym_reg;

    logic                    len_ok;
    logic [31:0]             mask32;
    logic [31:0]             code32;
    logic                    hit;

    // zero length or longer than the accumulator can hold: slot goes invalid
    assign len_ok = (wr_len != '0) &&
                    ({1'b0, wr_len} <= (LEN_IN_W + 1)'(MAX_CODE_LEN));
    assign mask32 = (32'd1 << wr_len) - 32'd1;
    assign code32 = 32'(wr_code) & mask32;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg <= len_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            len_reg  <= LEN_W'(wr_len);
            code_reg <= code32[MAX_CODE_LEN-1:0];
            sym_reg  <= wr_symbol;
        end
    end

    assign hit = valid_reg && (len_reg == accum_len) && (code_reg == accum);

    always_comb
    begin
        if (hit)
        begin
            chain_out.hit    = 1'b1;
            chain_out.symbol = sym_reg;
        end
        else
        begin
            chain_out = chain_in;
        end
    end

endmodule

// ===== design/hbd_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_table: row of code table cells with registered segment heads
// Cells are chained in segments; each segment's winner is registered, and the
// lowest hitting segment gives the match in the cycle after the code is shown.
// ----------------------------------------------------------------------------
module hbd_table
    import hbd_pkg::*;
#(
    parameter int MAX_CODE_LEN  = 16,
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [IDX_W-1:0]                    wr_index,
    input  logic [CODE_IN_W-1:0]                wr_code,
    input  logic [LEN_IN_W-1:0]                 wr_len,
    input  logic [SYM_W-1:0]                    wr_symbol,
    input  logic [MAX_CODE_LEN-1:0]             accum,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0]   accum_len,
    output link_t                               match
);

    localparam int GROUPS = (TABLE_ENTRIES + CHAIN_LEN - 1) / CHAIN_LEN;
    localparam int CELLS  = GROUPS * CHAIN_LEN;

    link_t chain [CELLS];
    link_t group_reg [GROUPS];

    for (genvar g = 0; g < GROUPS; g++)
    begin : g_group
        for (genvar c = 0; c < CHAIN_LEN; c++)
        begin : g_cell
            localparam int IDX = g * CHAIN_LEN + c;
            logic  cell_wr;
            link_t link_in;

            if (IDX < TABLE_ENTRIES)
            begin : g_live
                assign cell_wr = wr_en && (wr_index == IDX_W'(IDX));
            end
            else
            begin : g_pad
                assign cell_wr = 1'b0;
            end

            if (c == CHAIN_LEN - 1)
            begin : g_tail
                assign link_in = '0;
            end
            else
            begin : g_link
                assign link_in = chain[IDX + 1];
            end

            hbd_cell #(
                .MAX_CODE_LEN (MAX_CODE_LEN)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (cell_wr),
                .wr_code   (wr_code),
                .wr_len    (wr_len),
                .wr_symbol (wr_symbol),
                .accum     (accum),
                .accum_len (accum_len),
                .chain_in  (link_in),
                .chain_out (chain[IDX])
            );
        end

        always_ff @(posedge clk)
        begin
            group_reg[g] <= chain[g * CHAIN_LEN];
        end
    end

    // lowest segment with a hit wins
    always_comb
    begin
        match = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (group_reg[g].hit)
            begin
                match = group_reg[g];
            end
        end
    end

endmodule

// ===== design/huffman_bitstream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bitstream_decoder: prefix-code decoder with a loadable code table
// Input transactions either load one table slot (tuser[0] low) or bring one
// compressed byte (tuser[0] high), decoded most significant bit first.
// tuser[1] marks the first byte of a stream: it clears the accumulated code
// and drops skip_bits leading bits, taken from the cfg_wr_en/cfg_wr_data port.
// A load is taken in ST_IDLE. For each decoded bit of a data byte, ST_EVAL
// presents the code to the cell row and ST_DECIDE resolves the registered
// segment winners; ST_FLUSH then hands over the final symbol. New input is
// taken only in ST_IDLE. Each match gives one output transaction with the
// symbol in tdata; a code reaching the maximum length unmatched gives one with
// tuser high. tlast marks the last result of a byte. Up to eight per byte.
// A finished symbol is held while the next bit is decoded; when the receiver
// stalls, decoding waits at the next match or error until the output register drains.
// Reset invalidates every table slot, clears the accumulator and skip_bits.
// ----------------------------------------------------------------------------
module huffman_bitstream_decoder
    import hbd_pkg::*;
#(
    parameter int MAX_CODE_LEN  = 16,
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [SKIP_W-1:0]   cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [7:0] entry_index, [23:8] code_bits, [28:24] code_length,
    // [36:29] entry_symbol, [44:37] data_byte, [47:45] zero
    input  logic [47:0]         s_tdata,
    // [0] req_type, [1] first_byte
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [7:0] out_symbol
    output logic [7:0]          m_tdata,
    // [0] error
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
    localparam int IDX_LO  = 0;
    localparam int CODE_LO = IDX_LO + IDX_W;
    localparam int LEN_LO  = CODE_LO + CODE_IN_W;
    localparam int SYM_LO  = LEN_LO + LEN_IN_W;
    localparam int BYTE_LO = SYM_LO + SYM_W;

    hbd_state_t              state_reg, state_next;
    logic [SKIP_W-1:0]       skip_bits_reg;
    logic [MAX_CODE_LEN-1:0] accum_reg, accum_next;
    logic [LEN_W-1:0]        accum_len_reg, accum_len_next;
    logic [BYTE_W-1:0]       byte_reg, byte_next;
    logic [BITS_W-1:0]       bits_left_reg, bits_left_next;
    logic                    hold_valid_reg, hold_valid_next;
    logic [SYM_W-1:0]        hold_symbol_reg, hold_symbol_next;
    logic                    hold_error_reg, hold_error_next;
    logic                    m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]        m_symbol_reg, m_symbol_next;
    logic                    m_error_reg, m_error_next;
    logic                    m_last_reg, m_last_next;

    logic [IDX_W-1:0]        in_index;
    logic [CODE_IN_W-1:0]    in_code;
    logic [LEN_IN_W-1:0]     in_len;
    logic [SYM_W-1:0]        in_symbol;
    logic [BYTE_W-1:0]       in_byte;
    logic                    in_first;
    logic                    in_fire;
    logic                    fire_load;
    logic                    fire_data;
    logic [SKIP_W-1:0]       in_skip;
    logic [BYTE_W-1:0]       in_shifted;

    link_t                   match;
    logic                    m_free;
    logic                    dec_err;
    logic                    dec_res;
    logic                    dec_go;
    logic                    flush_go;

    assign in_index  = s_tdata[IDX_LO  +: IDX_W];
    assign in_code   = s_tdata[CODE_LO +: CODE_IN_W];
    assign in_len    = s_tdata[LEN_LO  +: LEN_IN_W];
    assign in_symbol = s_tdata[SYM_LO  +: SYM_W];
    assign in_byte   = s_tdata[BYTE_LO +: BYTE_W];
    assign in_first  = s_tuser[1];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign fire_load = in_fire && (s_tuser[0] == REQ_LOAD);
    assign fire_data = in_fire && (s_tuser[0] == REQ_DATA);

    // drop the leading padding bits of a stream's first byte
    assign in_skip    = in_first ? skip_bits_reg : '0;
    assign in_shifted = in_byte << in_skip;

    hbd_table #(
        .MAX_CODE_LEN  (MAX_CODE_LEN),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (fire_load),
        .wr_index  (in_index),
        .wr_code   (in_code),
        .wr_len    (in_len),
        .wr_symbol (in_symbol),
        .accum     (accum_reg),
        .accum_len (accum_len_reg),
        .match     (match)
    );

    assign m_free   = !m_valid_reg || m_tready;
    assign dec_err  = !match.hit && (accum_len_reg == LEN_W'(MAX_CODE_LEN));
    assign dec_res  = match.hit || dec_err;
    assign dec_go   = !dec_res || !hold_valid_reg || m_free;
    assign flush_go = !hold_valid_reg || m_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (fire_data)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (dec_go)
                begin
                    state_next = (bits_left_reg != '0) ? ST_EVAL : ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (flush_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        accum_next       = accum_reg;
        accum_len_next   = accum_len_reg;
        byte_next        = byte_reg;
        bits_left_next   = bits_left_reg;
        hold_valid_next  = hold_valid_reg;
        hold_symbol_next = hold_symbol_reg;
        hold_error_next  = hold_error_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_symbol_next    = m_symbol_reg;
        m_error_next     = m_error_reg;
        m_last_next      = m_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (fire_data)
                begin
                    // shift the first remaining bit straight in
                    if (in_first)
                    begin
                        accum_next     = MAX_CODE_LEN'(in_shifted[BYTE_W-1]);
                        accum_len_next = LEN_W'(1);
                    end
                    else
                    begin
                        accum_next     = (accum_reg << 1) |
                                         MAX_CODE_LEN'(in_shifted[BYTE_W-1]);
                        accum_len_next = accum_len_reg + LEN_W'(1);
                    end
                    byte_next      = in_shifted << 1;
                    bits_left_next = BITS_W'(BYTE_W - 1) - in_skip;
                end
            end
            ST_EVAL:
            begin
            end
            ST_DECIDE:
            begin
                if (dec_go)
                begin
                    if (dec_res)
                    begin
                        // older symbol is not the byte's last: send it on
                        if (hold_valid_reg)
                        begin
                            m_valid_next  = 1'b1;
                            m_symbol_next = hold_symbol_reg;
                            m_error_next  = hold_error_reg;
                            m_last_next   = 1'b0;
                        end
                        hold_valid_next  = 1'b1;
                        hold_symbol_next = match.hit ? match.symbol : '0;
                        hold_error_next  = dec_err;
                    end
                    if (bits_left_reg != '0)
                    begin
                        if (dec_res)
                        begin
                            accum_next     = MAX_CODE_LEN'(byte_reg[BYTE_W-1]);
                            accum_len_next = LEN_W'(1);
                        end
                        else
                        begin
                            accum_next     = (accum_reg << 1) |
                                             MAX_CODE_LEN'(byte_reg[BYTE_W-1]);
                            accum_len_next = accum_len_reg + LEN_W'(1);
                        end
                        byte_next      = byte_reg << 1;
                        bits_left_next = bits_left_reg - BITS_W'(1);
                    end
                    else if (dec_res)
                    begin
                        accum_next     = '0;
                        accum_len_next = '0;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (hold_valid_reg && m_free)
                begin
                    m_valid_next    = 1'b1;
                    m_symbol_next   = hold_symbol_reg;
                    m_error_next    = hold_error_reg;
                    m_last_next     = 1'b1;
                    hold_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            skip_bits_reg  <= '0;
            accum_reg      <= '0;
            accum_len_reg  <= '0;
            bits_left_reg  <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            accum_reg      <= accum_next;
            accum_len_reg  <= accum_len_next;
            bits_left_reg  <= bits_left_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en)
            begin
                skip_bits_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg        <= byte_next;
        hold_symbol_reg <= hold_symbol_next;
        hold_error_reg  <= hold_error_next;
        m_symbol_reg    <= m_symbol_next;
        m_error_reg     <= m_error_next;
        m_last_reg      <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_symbol_reg;
    assign m_tuser  = m_error_reg;
    assign m_tlast  = m_last_reg;

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accum_len_reg <= LEN_W'(MAX_CODE_LEN))
        else $error("accumulated code longer than the maximum code length");

    a_hold_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held symbol left over between bytes");

    a_stall_keeps_code: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && !dec_go) |=>
            ($stable(accum_reg) && $stable(accum_len_reg) && state_reg == ST_DECIDE))
        else $error("code changed while waiting for the output register");
`endif

endmodule

// ===== verif/huffman_bitstream_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bitstream_decoder_tb: self-checking bench for the prefix-code decoder
// A short table of directed transactions covers the table corner cases and
// pins the obvious results. Random prefix-code tables and compressed streams
// follow under three stall profiles and several skip settings. Each unpinned result is
// checked against a software decoder that mirrors the code table state.
// ----------------------------------------------------------------------------
module huffman_bitstream_decoder_tb;
    import hbd_pkg::*;

    localparam int MAX_LEN        = 16;
    localparam int TABLE_SIZE     = 256;
    localparam int SETTLE_CYCLES  = 40;    // wait after the last awaited result
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BATCH_ITEMS    = 60;
    localparam int NUM_ROWS       = 21;

    typedef struct packed {
        logic                 req;
        logic [IDX_W-1:0]     idx;
        logic [CODE_IN_W-1:0] code;
        logic [LEN_IN_W-1:0]  len;
        logic [SYM_W-1:0]     sym;
        logic [BYTE_W-1:0]    data;
        logic                 first;
    } stream_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             error;
        logic             last;
    } decoded_t;

    // How a directed row is checked: by the software decoder, or pinned
    typedef enum logic [1:0] {
        BY_DECODER,
        NO_RESULT,
        ONE_SYMBOL,
        ONE_ERROR
    } row_check_t;

    typedef struct packed {
        row_check_t           check;
        logic                 req;
        logic [IDX_W-1:0]     idx;
        logic [CODE_IN_W-1:0] code;
        logic [LEN_IN_W-1:0]  len;
        logic [SYM_W-1:0]     sym;
        logic [BYTE_W-1:0]    data;
        logic                 first;
        logic [SYM_W-1:0]     pin_symbol;
    } directed_row_t;

    // check, req, slot, code, length, symbol, byte, first, pinned symbol
    localparam directed_row_t DIRECTED_PLAN [0:NUM_ROWS-1] = '{
        // data before any stream start, empty table
        '{NO_RESULT,  REQ_DATA, 8'h00, 16'h0000, 5'd0,  8'h00, 8'hFF, 1'b0, 8'h00},
        '{ONE_ERROR,  REQ_DATA, 8'h00, 16'h0000, 5'd0,  8'h00, 8'h00, 1'b0, 8'h00},
        // stray code bits, then a duplicate code in a higher slot
        '{NO_RESULT,  REQ_LOAD, 8'd0,  16'hFFFE, 5'd1,  8'h41, 8'h00, 1'b0, 8'h00},
        '{NO_RESULT,  REQ_LOAD, 8'd5,  16'h0000, 5'd1,  8'h42, 8'h00, 1'b0, 8'h00},
        '{NO_RESULT,  REQ_LOAD, 8'd255, 16'h0001, 5'd1, 8'hFF, 8'h00, 1'b0, 8'h00},
        '{BY_DECODER, REQ_DATA, 8'hFF, 16'hFFFF, 5'h1F, 8'hFF, 8'h80, 1'b1, 8'h00},
        // overlong length clears slot 0, so slot 5 now wins
        '{NO_RESULT,  REQ_LOAD, 8'd0,  16'h0000, 5'd17, 8'h41, 8'hFF, 1'b1, 8'h00},
        '{BY_DECODER, REQ_DATA, 8'h00, 16'h0000, 5'd0,  8'h00, 8'h01, 1'b1, 8'h00},
        '{NO_RESULT,  REQ_LOAD, 8'd255, 16'h0001, 5'd0, 8'hFF, 8'h00, 1'b0, 8'h00},
        '{NO_RESULT,  REQ_LOAD, 8'd5,  16'h0000, 5'd31, 8'h42, 8'h00, 1'b0, 8'h00},
        // one maximum-length code only
        '{NO_RESULT,  REQ_LOAD, 8'd1,  16'hFFFF, 5'd16, 8'h00, 8'h00, 1'b0, 8'h00},
        '{NO_RESULT,  REQ_DATA, 8'h00, 16'h0000, 5'd0,  8'h00, 8'hFF, 1'b1, 8'h00},
        '{ONE_SYMBOL, REQ_DATA, 8'h00, 16'h0000, 5'd0,  8'h00, 8'hFF, 1'b0, 8'h00},
        // leftover bits are dropped by the next stream start
        '{NO_RESULT,  REQ_DATA, 8'h00, 16'h0000, 5'd0,  8'h00, 8'hFF, 1'b0, 8'h00},
        '{NO_RESULT,  REQ_DATA, 8'h00, 16'h0000, 5'd0,  8'h00, 8'hFF, 1'b1, 8'h00},
        '{ONE_ERROR,  REQ_DATA, 8'h00, 16'h0000, 5'd0,  8'h00, 8'h7F, 1'b0, 8'h00},
        // complete code {0, 10, 11}
        '{NO_RESULT,  REQ_LOAD, 8'd128, 16'hABCE, 5'd2, 8'h5A, 8'h00, 1'b0, 8'h00},
        '{NO_RESULT,  REQ_LOAD, 8'd64, 16'hFFFF, 5'd2,  8'hA5, 8'h00, 1'b0, 8'h00},
        '{NO_RESULT,  REQ_LOAD, 8'd200, 16'h0000, 5'd1, 8'h01, 8'h00, 1'b0, 8'h00},
        '{BY_DECODER, REQ_DATA, 8'h00, 16'h0000, 5'd0,  8'h00, 8'hB4, 1'b1, 8'h00},
        '{BY_DECODER, REQ_DATA, 8'h00, 16'h0000, 5'd0,  8'h00, 8'h5A, 1'b0, 8'h00}
    };

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [SKIP_W-1:0]   cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [47:0]         s_tdata     = '0;
    logic [1:0]          s_tuser     = '0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [7:0]          m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    // Software copy of the decoder state
    logic                 slot_valid [TABLE_SIZE] = '{default: 1'b0};
    logic [LEN_IN_W-1:0]  slot_len   [TABLE_SIZE];
    logic [CODE_IN_W-1:0] slot_code  [TABLE_SIZE];
    logic [SYM_W-1:0]     slot_sym   [TABLE_SIZE];
    logic [CODE_IN_W-1:0] acc_code   = '0;
    int                   acc_len    = 0;
    int                   skip_left  = 0;
    logic [SKIP_W-1:0]    skip_cfg   = '0;

    decoded_t   awaited_results [$];
    logic [7:0] loaded_slots [$];
    int         failures      = 0;
    int         items_sent    = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    huffman_bitstream_decoder #(
        .MAX_CODE_LEN  (MAX_LEN),
        .TABLE_ENTRIES (TABLE_SIZE)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #5 clk = ~clk;

    // Update the table copy, or decode one byte and queue its symbols
    function automatic void decode_transaction(input stream_item_t it);
        decoded_t            batch [8];
        int                  produced;
        int                  hit;
        int                  b;
        int                  k;
        logic [CODE_IN_W-1:0] mask;
        produced = 0;
        if (it.req == REQ_LOAD)
        begin
            if (it.len == 0 || it.len > MAX_LEN)
            begin
                slot_valid[it.idx] = 1'b0;
            end
            else
            begin
                mask = CODE_IN_W'((32'd1 << it.len) - 32'd1);
                slot_valid[it.idx] = 1'b1;
                slot_len[it.idx]   = it.len;
                slot_code[it.idx]  = it.code & mask;
                slot_sym[it.idx]   = it.sym;
            end
            return;
        end
        if (it.first)
        begin
            acc_code  = '0;
            acc_len   = 0;
            skip_left = skip_cfg;
        end
        for (b = 7; b >= 0; b--)
        begin
            if (skip_left > 0)
            begin
                skip_left--;
                continue;
            end
            acc_code = {acc_code[CODE_IN_W-2:0], it.data[b]};
            acc_len++;
            hit = -1;
            for (k = 0; k < TABLE_SIZE && hit < 0; k++)
            begin
                if (slot_valid[k] && slot_len[k] == acc_len && slot_code[k] == acc_code)
                    hit = k;
            end
            if (hit >= 0 || acc_len >= MAX_LEN)
            begin
                batch[produced] = (hit >= 0) ? {slot_sym[hit], 1'b0, 1'b0}
                                             : {8'h00, 1'b1, 1'b0};
                produced++;
                acc_code = '0;
                acc_len  = 0;
            end
        end
        for (k = 0; k < produced; k++)
        begin
            if (k == produced - 1)
                batch[k].last = 1'b1;
            awaited_results.push_back(batch[k]);
        end
    endfunction

    function automatic stream_item_t rand_item();
        stream_item_t it;
        it.req   = 1'($urandom);
        it.idx   = 8'($urandom);
        it.code  = 16'($urandom);
        it.len   = 5'($urandom);
        it.sym   = 8'($urandom);
        it.data  = 8'($urandom);
        it.first = 1'($urandom);
        return it;
    endfunction

    task automatic send_item(input stream_item_t it, input row_check_t check,
                             input logic [SYM_W-1:0] pin_symbol);
        int depth;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.data, it.sym, it.len, it.code, it.idx};
        s_tuser  <= {it.first, it.req};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        depth = awaited_results.size();
        decode_transaction(it);
        if (check != BY_DECODER)
        begin
            // pinned row: replace the decoder's results with the typed one
            while (awaited_results.size() > depth)
                void'(awaited_results.pop_back());
            if (check == ONE_SYMBOL)
                awaited_results.push_back({pin_symbol, 1'b0, 1'b1});
            else if (check == ONE_ERROR)
                awaited_results.push_back({8'h00, 1'b1, 1'b1});
        end
        items_sent++;
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [15:0] code,
                             input logic [4:0] len, input logic [7:0] sym);
        stream_item_t it;
        it      = rand_item();
        it.req  = REQ_LOAD;
        it.idx  = idx;
        it.code = code;
        it.len  = len;
        it.sym  = sym;
        loaded_slots.push_back(idx);
        send_item(it, BY_DECODER, 8'h00);
    endtask

    task automatic send_data(input logic [7:0] data, input logic first);
        stream_item_t it;
        it       = rand_item();
        it.req   = REQ_DATA;
        it.data  = data;
        it.first = first;
        send_item(it, BY_DECODER, 8'h00);
    endtask

    // Hold the sender until every symbol is out and the decoder has gone quiet
    task automatic drain_decoder();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_skip(input logic [SKIP_W-1:0] value);
        drain_decoder();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        skip_cfg     = value;
    endtask

    // Mostly fresh prefix-code tables followed by a stream; the rest is noise
    task automatic run_random(input int count);
        logic [15:0]  leaf_code [$];
        int           leaf_len  [$];
        logic [7:0]   stale     [$];
        logic [15:0]  stray;
        logic [7:0]   slot;
        stream_item_t it;
        int           stop;
        int           n_leaves;
        int           deep;
        int           guard;
        int           j;
        int           base;
        int           step;
        int           nbytes;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            if ($urandom_range(99) >= 80)
            begin
                it = rand_item();
                if (it.req == REQ_LOAD)
                    loaded_slots.push_back(it.idx);
                send_item(it, BY_DECODER, 8'h00);
                continue;
            end
            // split leaves of a full binary tree to get a complete code
            leaf_code = '{16'h0000, 16'h0001};
            leaf_len  = '{1, 1};
            deep      = ($urandom_range(99) < 15);
            n_leaves  = deep ? MAX_LEN + 1 : $urandom_range(2, 12);
            guard     = 0;
            while (leaf_code.size() < n_leaves && guard < 200)
            begin
                guard++;
                j = (deep || $urandom_range(99) < 30) ? leaf_code.size() - 1
                                                      : $urandom_range(leaf_code.size() - 1);
                if (leaf_len[j] < MAX_LEN)
                begin
                    leaf_code.push_back({leaf_code[j][14:0], 1'b1});
                    leaf_len.push_back(leaf_len[j] + 1);
                    leaf_code[j] = {leaf_code[j][14:0], 1'b0};
                    leaf_len[j]  = leaf_len[j] + 1;
                end
            end
            // drop one code now and then so that unmatched paths run to an error
            if ($urandom_range(99) < 20)
            begin
                j = $urandom_range(leaf_code.size() - 1);
                leaf_code.delete(j);
                leaf_len.delete(j);
            end
            // invalidate the slots of earlier tables; they need no tracking after
            if ($urandom_range(99) < 70)
            begin
                stale = loaded_slots;
                loaded_slots.delete();
                foreach (stale[j])
                begin
                    it      = rand_item();
                    it.req  = REQ_LOAD;
                    it.idx  = stale[j];
                    it.len  = $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31));
                    send_item(it, BY_DECODER, 8'h00);
                end
            end
            base = $urandom_range(255);
            step = 2 * $urandom_range(127) + 1;
            foreach (leaf_code[j])
            begin
                stray = 16'($urandom) << leaf_len[j];
                send_load(8'(base + j * step), leaf_code[j] | stray,
                          5'(leaf_len[j]), 8'($urandom));
            end
            if ($urandom_range(99) < 10)
            begin
                j    = $urandom_range(leaf_code.size() - 1);
                slot = 8'(base + leaf_code.size() * step);
                send_load(slot, leaf_code[j], 5'(leaf_len[j]), 8'($urandom));
            end
            nbytes = $urandom_range(2, 10);
            for (j = 0; j < nbytes; j++)
                send_data(8'($urandom), (j == 0) || ($urandom_range(99) < 5));
        end
    endtask

    // Receiver stalls and result checking
    always @(posedge clk)
    begin
        decoded_t want;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: out_symbol %0h error %0b last %0b",
                       m_tdata, m_tuser, m_tlast);
                failures++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_tdata !== want.symbol)
                begin
                    $error("out_symbol: expected %0h, got %0h", want.symbol, m_tdata);
                    failures++;
                end
                if (m_tuser !== want.error)
                begin
                    $error("error: expected %0b, got %0b", want.error, m_tuser);
                    failures++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    failures++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        stream_item_t it;
        int           r;
        int           phase;
        int           send_pct [3];
        int           recv_pct [3];
        logic [2:0]   skip_plan [6];
        send_pct  = '{26, 67, 0};
        recv_pct  = '{67, 26, 0};
        skip_plan = '{3'd7, 3'd0, 3'($urandom), 3'd3, 3'd7, 3'($urandom)};
        send_idle_pct = send_pct[0];
        recv_idle_pct = recv_pct[0];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < NUM_ROWS; r++)
        begin
            it.req   = DIRECTED_PLAN[r].req;
            it.idx   = DIRECTED_PLAN[r].idx;
            it.code  = DIRECTED_PLAN[r].code;
            it.len   = DIRECTED_PLAN[r].len;
            it.sym   = DIRECTED_PLAN[r].sym;
            it.data  = DIRECTED_PLAN[r].data;
            it.first = DIRECTED_PLAN[r].first;
            if (it.req == REQ_LOAD)
                loaded_slots.push_back(it.idx);
            send_item(it, DIRECTED_PLAN[r].check, DIRECTED_PLAN[r].pin_symbol);
        end

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = send_pct[phase];
            recv_idle_pct = recv_pct[phase];
            write_skip(skip_plan[2 * phase]);
            run_random(BATCH_ITEMS);
            write_skip(skip_plan[2 * phase + 1]);
            run_random(BATCH_ITEMS);
        end

        drain_decoder();
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
design/hbd_pkg.sv
design/hbd_cell.sv
design/hbd_table.sv
design/huffman_bitstream_decoder.sv
verif/huffman_bitstream_decoder_tb.sv
